@@ design/eiup_pkg.sv @@
`default_nettype none

package eiup_pkg;

  // sizing
  localparam int MAX_LAYERS      = 4;
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int IDEAL_LAYERS    = 4;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CNT_W           = $clog2(MAX_LAYERS + 1);
  localparam int OFS_W           = 12;
  localparam int KIND_W          = 3;
  localparam int NUM_W           = 2;

  // layer kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ETH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UDP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DATA = 3'd4;

  // header geometry
  localparam int ETH_HDR_BYTES = 14;
  localparam int IP_MIN_BYTES  = 20;
  localparam int UDP_HDR_BYTES = 8;
  localparam int POS_ET_HI     = 12;
  localparam int POS_ET_LO     = 13;
  localparam int POS_IHL       = 14;
  localparam int POS_PROTO     = 23;
  localparam int UDP_LEN_OFS   = 4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // header fields captured over one frame, handed over at its last byte
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic             link;
    logic [15:0]      ethertype;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [15:0]      udp_len;
    logic             overlong;
  } snap_t;

  // one layer of the split
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
  } layer_t;

endpackage

`default_nettype wire

@@ design/eiup_capture.sv @@
`default_nettype none

module eiup_capture (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_frame_byte,
  input  wire logic                 in_frame_end,
  input  wire logic                 link_is_ethernet,
  output logic                      snap_valid,
  output eiup_pkg::snap_t           snap,
  input  wire logic                 snap_take
);

  logic [eiup_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                et_r, et_nxt;
  logic [3:0]                 ihl_r, ihl_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [15:0]                ulen_r, ulen_nxt;
  logic                       ovl_r, ovl_nxt;
  logic                       snap_v_r, snap_v_nxt;
  eiup_pkg::snap_t            snap_r, snap_nxt;
  logic [eiup_pkg::POS_W-1:0] udp_at;
  logic                       xfer;
  logic                       frame_done;

  // a last byte waits while the previous frame's fields are still held
  assign in_stall   = in_frame_end && snap_v_r && !snap_take;
  assign xfer       = in_valid && !in_stall;
  assign frame_done = xfer && in_frame_end;

  // offset of the udp length field behind the ip header
  assign udp_at = eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES + eiup_pkg::UDP_LEN_OFS)
                + eiup_pkg::POS_W'({ihl_r, 2'b00});

  // header field capture per byte
  always_comb begin
    pos_nxt   = pos_r;
    et_nxt    = et_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    ulen_nxt  = ulen_r;
    ovl_nxt   = ovl_r;
    if (xfer) begin
      if (pos_r < eiup_pkg::POS_W'(eiup_pkg::MAX_FRAME_BYTES)) begin
        if (pos_r == eiup_pkg::POS_W'(eiup_pkg::POS_ET_HI)) begin
          et_nxt[15:8] = in_frame_byte;
        end else if (pos_r == eiup_pkg::POS_W'(eiup_pkg::POS_ET_LO)) begin
          et_nxt[7:0] = in_frame_byte;
        end else if (pos_r == eiup_pkg::POS_W'(eiup_pkg::POS_IHL)) begin
          ihl_nxt = in_frame_byte[3:0];
        end
        if (pos_r == eiup_pkg::POS_W'(eiup_pkg::POS_PROTO)) begin
          proto_nxt = in_frame_byte;
        end
        if (pos_r > eiup_pkg::POS_W'(eiup_pkg::POS_IHL)) begin
          if (pos_r == udp_at) begin
            ulen_nxt[15:8] = in_frame_byte;
          end else if (pos_r == udp_at + eiup_pkg::POS_W'(1)) begin
            ulen_nxt[7:0] = in_frame_byte;
          end
        end
        pos_nxt = pos_r + eiup_pkg::POS_W'(1);
      end else begin
        ovl_nxt = 1'b1;
      end
    end

    snap_nxt.len       = pos_nxt;
    snap_nxt.link      = link_is_ethernet;
    snap_nxt.ethertype = et_nxt;
    snap_nxt.ihl       = ihl_nxt;
    snap_nxt.proto     = proto_nxt;
    snap_nxt.udp_len   = ulen_nxt;
    snap_nxt.overlong  = ovl_nxt;

    // fresh state for the next frame
    if (frame_done) begin
      pos_nxt   = '0;
      et_nxt    = '0;
      ihl_nxt   = '0;
      proto_nxt = '0;
      ulen_nxt  = '0;
      ovl_nxt   = 1'b0;
    end

    snap_v_nxt = frame_done || (snap_v_r && !snap_take);
  end

  // per-frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      et_r     <= '0;
      ihl_r    <= '0;
      proto_r  <= '0;
      ulen_r   <= '0;
      ovl_r    <= 1'b0;
      snap_v_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      et_r     <= et_nxt;
      ihl_r    <= ihl_nxt;
      proto_r  <= proto_nxt;
      ulen_r   <= ulen_nxt;
      ovl_r    <= ovl_nxt;
      snap_v_r <= snap_v_nxt;
    end
  end

  // finished frame fields
  always_ff @(posedge clk) begin
    if (frame_done) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

@@ design/eiup_emit.sv @@
`default_nettype none

module eiup_emit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          snap_valid,
  input  wire eiup_pkg::snap_t               snap,
  output logic                               snap_take,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [eiup_pkg::NUM_W-1:0]         out_layer_number,
  output logic [eiup_pkg::KIND_W-1:0]        out_layer_kind,
  output logic [eiup_pkg::OFS_W-1:0]         out_layer_start,
  output logic [eiup_pkg::OFS_W-1:0]         out_layer_stop,
  output logic                               out_frame_ok,
  output logic                               out_final_layer
);

  eiup_pkg::layer_t            list_r [eiup_pkg::MAX_LAYERS];
  eiup_pkg::layer_t            list_nxt [eiup_pkg::MAX_LAYERS];
  eiup_pkg::layer_t            ideal [eiup_pkg::IDEAL_LAYERS];
  logic [eiup_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [eiup_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic                        ok_r, ok_nxt;
  logic [2:0]                  n_ideal;
  logic                        ok_ideal;
  logic [eiup_pkg::CNT_W-1:0]  cnt;
  logic [eiup_pkg::POS_W-1:0]  len;
  logic [eiup_pkg::POS_W-1:0]  ip_end;
  logic [eiup_pkg::POS_W-1:0]  udp_end;
  logic [eiup_pkg::POS_W-1:0]  udp_rem;
  logic                        xfer;
  logic                        last;

  assign out_valid = (rem_r != '0);
  assign xfer      = out_valid && !out_stall;
  assign last      = (rem_r == eiup_pkg::CNT_W'(1));
  assign snap_take = snap_valid && (!out_valid || (xfer && last));

  assign len     = snap.len;
  assign ip_end  = eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES)
                 + eiup_pkg::POS_W'({snap.ihl, 2'b00});
  assign udp_end = ip_end + eiup_pkg::POS_W'(eiup_pkg::UDP_HDR_BYTES);
  assign udp_rem = len - ip_end;

  // layer split of the held frame
  always_comb begin
    for (int i = 0; i < eiup_pkg::IDEAL_LAYERS; i++) begin
      ideal[i] = '{kind: eiup_pkg::KIND_NONE, start: '0, stop: '0};
    end
    n_ideal  = 3'd0;
    ok_ideal = 1'b0;
    if (!snap.link) begin
      ideal[0] = '{kind: eiup_pkg::KIND_DATA, start: '0, stop: len};
      n_ideal  = 3'd1;
      ok_ideal = 1'b1;
    end else if (len >= eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES)) begin
      ideal[0] = '{kind: eiup_pkg::KIND_ETH, start: '0,
                   stop: eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES)};
      if (snap.ethertype != eiup_pkg::ETHERTYPE_IPV4) begin
        ideal[1] = '{kind: eiup_pkg::KIND_DATA,
                     start: eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES), stop: len};
        n_ideal  = 3'd2;
        ok_ideal = 1'b1;
      end else if (len < eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES + eiup_pkg::IP_MIN_BYTES)
                   || len < ip_end) begin
        n_ideal = 3'd1;
      end else begin
        ideal[1] = '{kind: eiup_pkg::KIND_IP,
                     start: eiup_pkg::POS_W'(eiup_pkg::ETH_HDR_BYTES), stop: ip_end};
        if (snap.proto != eiup_pkg::PROTO_UDP) begin
          ideal[2] = '{kind: eiup_pkg::KIND_DATA, start: ip_end, stop: len};
          n_ideal  = 3'd3;
          ok_ideal = 1'b1;
        end else if (udp_rem < eiup_pkg::POS_W'(eiup_pkg::UDP_HDR_BYTES)
                     || 16'(udp_rem) != snap.udp_len) begin
          n_ideal = 3'd2;
        end else begin
          ideal[2] = '{kind: eiup_pkg::KIND_UDP, start: ip_end, stop: udp_end};
          ideal[3] = '{kind: eiup_pkg::KIND_DATA, start: udp_end, stop: len};
          n_ideal  = 3'd4;
          ok_ideal = 1'b1;
        end
      end
    end
  end

  // layers beyond the list depth are dropped and fail the frame
  assign cnt = (n_ideal > 3'(eiup_pkg::MAX_LAYERS)) ? eiup_pkg::CNT_W'(eiup_pkg::MAX_LAYERS)
                                                    : eiup_pkg::CNT_W'(n_ideal);

  // layer list: load a frame, shift one layer out per transfer
  always_comb begin
    list_nxt = list_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    ok_nxt   = ok_r;
    if (snap_take) begin
      for (int i = 0; i < eiup_pkg::MAX_LAYERS; i++) begin
        list_nxt[i] = ideal[i];
      end
      num_nxt = '0;
      if (cnt == '0) begin
        rem_nxt = eiup_pkg::CNT_W'(1);
        ok_nxt  = 1'b0;
      end else begin
        rem_nxt = cnt;
        ok_nxt  = ok_ideal && (n_ideal <= 3'(eiup_pkg::MAX_LAYERS)) && !snap.overlong;
      end
    end else if (xfer) begin
      for (int i = 0; i < eiup_pkg::MAX_LAYERS - 1; i++) begin
        list_nxt[i] = list_r[i+1];
      end
      rem_nxt = rem_r - eiup_pkg::CNT_W'(1);
      num_nxt = num_r + eiup_pkg::NUM_W'(1);
    end
  end

  // result control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      num_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    list_r <= list_nxt;
    ok_r   <= ok_nxt;
  end

  assign out_layer_number = num_r;
  assign out_layer_kind   = list_r[0].kind;
  assign out_layer_start  = list_r[0].start[eiup_pkg::OFS_W-1:0];
  assign out_layer_stop   = list_r[0].stop[eiup_pkg::OFS_W-1:0];
  assign out_frame_ok     = ok_r;
  assign out_final_layer  = last;

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= eiup_pkg::CNT_W'(eiup_pkg::MAX_LAYERS))
    else $error("layer count beyond list depth");

  a_take_needs_snap: assert property (@(posedge clk) disable iff (!rst_n)
    snap_take |-> snap_valid)
    else $error("frame taken without held fields");

  a_none_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_layer_kind == eiup_pkg::KIND_NONE
      |-> !out_frame_ok && out_final_layer && out_layer_number == '0)
    else $error("empty-frame result malformed");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && last && !snap_take |=> !out_valid)
    else $error("results continue after final layer");

  a_number_steps: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !last |=> out_valid && out_layer_number == $past(out_layer_number) + 2'd1)
    else $error("layer number did not advance");
`endif

endmodule

`default_nettype wire

@@ design/eth_ip_udp_layer_parser.sv @@
`default_nettype none

// channel   direction  handshake           payload
// in_       input      in_valid/in_stall    in_frame_byte, in_frame_end
// out_      output     out_valid/out_stall  out_layer_number/kind/start/stop,
//                                           out_frame_ok, out_final_layer
// cfg_      input      cfg_we               cfg_wdata (link_is_ethernet)
//
// one frame byte is taken every cycle unless in_stall holds it; header fields are captured on the fly
// the first layer result of a frame passes the captured fields register and then the layer list register,
// then one layer per cycle while out_stall is low, up to four per frame from the layer list register
// a last byte stalls only while the previous frame's fields still wait, i.e.
// while the list drains under output stalls or outlasts a shorter next frame
// reset is synchronous, active low; link_is_ethernet comes up as 1

module eth_ip_udp_layer_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_frame_byte,
  input  wire logic                          in_frame_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [eiup_pkg::NUM_W-1:0]         out_layer_number,
  output logic [eiup_pkg::KIND_W-1:0]        out_layer_kind,
  output logic [eiup_pkg::OFS_W-1:0]         out_layer_start,
  output logic [eiup_pkg::OFS_W-1:0]         out_layer_stop,
  output logic                               out_frame_ok,
  output logic                               out_final_layer,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata
);

  logic            link_r;
  logic            snap_valid;
  logic            snap_take;
  eiup_pkg::snap_t snap;

  // link type register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= 1'b1;
    end else if (cfg_we) begin
      link_r <= cfg_wdata;
    end
  end

  // byte tracking and header capture
  eiup_capture u_capture (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_byte    (in_frame_byte),
    .in_frame_end     (in_frame_end),
    .link_is_ethernet (link_r),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .snap_take        (snap_take)
  );

  // layer split and result output
  eiup_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .snap_take        (snap_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_layer_number (out_layer_number),
    .out_layer_kind   (out_layer_kind),
    .out_layer_start  (out_layer_start),
    .out_layer_stop   (out_layer_stop),
    .out_frame_ok     (out_frame_ok),
    .out_final_layer  (out_final_layer)
  );

endmodule

`default_nettype wire
